FILE: rtl/core/stm_pkg.sv
// shared types, constants and helpers for the scrolling text marquee
// no dependencies
`default_nettype none

package stm_pkg;

  localparam int TEXT_DEPTH  = 256;
  localparam int TEXT_AW     = $clog2(TEXT_DEPTH);
  localparam int RP_W        = TEXT_AW + 1;
  localparam int GLYPH_COUNT = 64;
  localparam int GLYPH_AW    = $clog2(GLYPH_COUNT);
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

  localparam logic [2:0] OP_TICK        = 3'd0;
  localparam logic [2:0] OP_WRITE_CHAR  = 3'd1;
  localparam logic [2:0] OP_WRITE_GLYPH = 3'd2;
  localparam logic [2:0] OP_START       = 3'd3;
  localparam logic [2:0] OP_STOP        = 3'd4;

  localparam logic [7:0] CHAR_SPACE     = 8'd32;
  localparam logic [7:0] CHAR_FIRST_OUT = 8'd128;
  localparam logic [7:0] CHAR_LOWER     = 8'd96;
  localparam logic [7:0] CHAR_TERM      = 8'd0;
  localparam logic [7:0] FOLD_MASK      = 8'h5F;

  // one resolved frame: glyph words of the three window letters, scroll offset and done flag
  typedef struct packed {
    logic [2:0][15:0] glyphs;
    logic [1:0]       offset;
    logic             done;
  } frame_t;

  function automatic logic [GLYPH_AW-1:0] glyph_index(input logic [7:0] code);
    logic [7:0] c;
    c = code;
    if (c < CHAR_SPACE || c >= CHAR_FIRST_OUT) begin
      c = CHAR_SPACE;
    end else if (c >= CHAR_LOWER) begin
      c = c & FOLD_MASK;
    end
    c = c - CHAR_SPACE;
    return c[GLYPH_AW-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/scrolling_text_marquee.sv
// top level of the scrolling text marquee: register port, front sequencer,
// frame queue and pixel generator; uses stm_pkg, stm_front, stm_fifo, stm_back
`default_nettype none

// Ops other than a frame-ending tick leave the front idle, so the input stays
// ready. A tick that ends the frame period reads the text store when a
// character shifts in, then fetches the three glyph words from the font memory
// and queues the frame once the queue has room; the pixel generator then emits
// the 32 pixels of the frame at one per cycle while the output is taken. The
// two-entry frame queue lets the front take further ops while pixels are still
// going out. The text and font stores are not cleared at reset and must be
// loaded before use.
module scrolling_text_marquee (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_op,
  input  wire logic [7:0]  in_text_slot,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [5:0]  in_glyph_index,
  input  wire logic [15:0] in_glyph_bits,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_pixel_x,
  output logic [2:0]       out_pixel_y,
  output logic             out_lit,
  output logic             out_last,
  output logic             out_finished,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic       REG_FRAME_PERIOD = 1'b0;
  localparam logic       REG_BASE_ROW     = 1'b1;
  localparam logic [7:0] FRAME_PERIOD_RST = 8'd90;
  localparam logic [2:0] BASE_ROW_MAX     = 3'd4;

  logic [7:0]      frame_period_r;
  logic [2:0]      base_row_r;
  logic            cfg_wr;
  logic [2:0]      row_wdata;

  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_valid;
  stm_pkg::frame_t q_wframe;
  stm_pkg::frame_t q_rframe;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign row_wdata = (pwdata[2:0] > BASE_ROW_MAX) ? BASE_ROW_MAX : pwdata[2:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_period_r <= FRAME_PERIOD_RST;
      base_row_r     <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_FRAME_PERIOD: frame_period_r <= pwdata[7:0];
        REG_BASE_ROW:     base_row_r     <= row_wdata;
        default: ;
      endcase
    end
  end

  // misaligned reads return zero
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      case (paddr[2])
        REG_FRAME_PERIOD: prdata = {24'd0, frame_period_r};
        REG_BASE_ROW:     prdata = {29'd0, base_row_r};
        default:          prdata = '0;
      endcase
    end
  end

  stm_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_text_slot   (in_text_slot),
    .in_char_code   (in_char_code),
    .in_glyph_index (in_glyph_index),
    .in_glyph_bits  (in_glyph_bits),
    .frame_period   (frame_period_r),
    .q_push         (q_push),
    .q_frame        (q_wframe),
    .q_full         (q_full)
  );

  stm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wframe),
    .full      (q_full),
    .pop       (q_pop),
    .rdata     (q_rframe),
    .not_empty (q_valid)
  );

  stm_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_frame      (q_rframe),
    .q_pop        (q_pop),
    .base_row     (base_row_r),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_pixel_x  (out_pixel_x),
    .out_pixel_y  (out_pixel_y),
    .out_lit      (out_lit),
    .out_last     (out_last),
    .out_finished (out_finished)
  );

endmodule

`default_nettype wire

FILE: rtl/core/stm_fifo.sv
// short frame queue between the front sequencer and the pixel generator
// uses stm_pkg for the frame type and depth
`default_nettype none

module stm_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  stm_pkg::frame_t      wdata,
  output logic                 full,
  input  wire logic            pop,
  output stm_pkg::frame_t      rdata,
  output logic                 not_empty
);

  stm_pkg::frame_t                  mem_r [stm_pkg::FIFO_DEPTH];
  logic [stm_pkg::FIFO_AW-1:0]      wptr_r, wptr_nxt;
  logic [stm_pkg::FIFO_AW-1:0]      rptr_r, rptr_nxt;
  logic [stm_pkg::FIFO_CW-1:0]      count_r, count_nxt;
  logic                             do_push, do_pop;

  assign full      = (count_r == stm_pkg::FIFO_CW'(stm_pkg::FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign rdata     = mem_r[rptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == stm_pkg::FIFO_AW'(stm_pkg::FIFO_DEPTH - 1)) ? '0
                 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == stm_pkg::FIFO_AW'(stm_pkg::FIFO_DEPTH - 1)) ? '0
                 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/stm_front.sv
// front sequencer: takes ops, owns text and glyph stores, scroll state and
// frame timing, and hands resolved frames to the queue; uses stm_pkg
`default_nettype none

module stm_front (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_op,
  input  wire logic [7:0]  in_text_slot,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [5:0]  in_glyph_index,
  input  wire logic [15:0] in_glyph_bits,
  input  wire logic [7:0]  frame_period,
  output logic             q_push,
  output stm_pkg::frame_t  q_frame,
  input  wire logic        q_full
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_TEXT  = 2'd1;
  localparam logic [1:0] ST_GLYPH = 2'd2;
  localparam logic [1:0] GC_LAST  = 2'd3;

  logic [1:0]                   state_r, state_nxt;
  logic                         running_r, running_nxt;
  logic [7:0]                   countdown_r, countdown_nxt;
  logic [1:0]                   offset_r, offset_nxt;
  logic [2:0][7:0]              win_r, win_nxt;
  logic [stm_pkg::RP_W-1:0]     read_pos_r, read_pos_nxt;
  logic [1:0]                   gc_r, gc_nxt;
  logic [1:0][15:0]             glyphs_r, glyphs_nxt;

  logic [7:0]                   text_mem [stm_pkg::TEXT_DEPTH];
  logic [15:0]                  glyph_mem [stm_pkg::GLYPH_COUNT];
  logic [7:0]                   text_q;
  logic [15:0]                  glyph_q;

  logic                         accept;
  logic                         slot_ok;
  logic                         pos_ok;
  logic [7:0]                   next_char;
  logic [7:0]                   sel_char;
  logic [stm_pkg::GLYPH_AW-1:0] gaddr;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_ok   = ({24'd0, in_text_slot} < 32'(stm_pkg::TEXT_DEPTH));
  assign pos_ok    = (read_pos_r < stm_pkg::RP_W'(stm_pkg::TEXT_DEPTH));
  assign next_char = pos_ok ? text_q : stm_pkg::CHAR_TERM;

  // letter whose glyph is fetched this cycle, the last one is held while waiting
  always_comb begin
    case (gc_r)
      2'd0:    sel_char = win_r[0];
      2'd1:    sel_char = win_r[1];
      default: sel_char = win_r[2];
    endcase
  end
  assign gaddr = stm_pkg::glyph_index(sel_char);

  assign q_frame.glyphs = {glyph_q, glyphs_r[1], glyphs_r[0]};
  assign q_frame.offset = offset_r;
  assign q_frame.done   = (win_r[0] == stm_pkg::CHAR_TERM);

  always_comb begin
    state_nxt     = state_r;
    running_nxt   = running_r;
    countdown_nxt = countdown_r;
    offset_nxt    = offset_r;
    win_nxt       = win_r;
    read_pos_nxt  = read_pos_r;
    gc_nxt        = gc_r;
    glyphs_nxt    = glyphs_r;
    q_push        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_op)
            stm_pkg::OP_START: begin
              win_nxt       = {3{stm_pkg::CHAR_SPACE}};
              read_pos_nxt  = '0;
              countdown_nxt = '0;
              offset_nxt    = 2'd3;
              running_nxt   = 1'b1;
            end
            stm_pkg::OP_STOP: begin
              running_nxt = 1'b0;
            end
            stm_pkg::OP_TICK: begin
              if (running_r) begin
                if (countdown_r != '0) begin
                  countdown_nxt = countdown_r - 1'b1;
                end else begin
                  countdown_nxt = frame_period;
                  offset_nxt    = offset_r + 1'b1;
                  gc_nxt        = '0;
                  // offset wraps to zero: a new character shifts in first
                  state_nxt     = (offset_r == 2'd3) ? ST_TEXT : ST_GLYPH;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_TEXT: begin
        win_nxt[0] = win_r[1];
        win_nxt[1] = win_r[2];
        win_nxt[2] = next_char;
        if (next_char != stm_pkg::CHAR_TERM) begin
          read_pos_nxt = read_pos_r + 1'b1;
        end
        state_nxt = ST_GLYPH;
      end
      ST_GLYPH: begin
        if (gc_r != GC_LAST) begin
          gc_nxt = gc_r + 1'b1;
        end
        case (gc_r)
          2'd1:    glyphs_nxt[0] = glyph_q;
          2'd2:    glyphs_nxt[1] = glyph_q;
          default: ;
        endcase
        if (gc_r == GC_LAST && !q_full) begin
          q_push    = 1'b1;
          state_nxt = ST_IDLE;
          if (q_frame.done) begin
            running_nxt = 1'b0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      running_r   <= 1'b0;
      countdown_r <= '0;
      offset_r    <= '0;
      win_r       <= {3{stm_pkg::CHAR_SPACE}};
      read_pos_r  <= '0;
      gc_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      running_r   <= running_nxt;
      countdown_r <= countdown_nxt;
      offset_r    <= offset_nxt;
      win_r       <= win_nxt;
      read_pos_r  <= read_pos_nxt;
      gc_r        <= gc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    glyphs_r <= glyphs_nxt;
  end

  always_ff @(posedge clk) begin
    if (accept && in_op == stm_pkg::OP_WRITE_CHAR && slot_ok) begin
      text_mem[stm_pkg::TEXT_AW'(in_text_slot)] <= in_char_code;
    end
    text_q <= text_mem[read_pos_r[stm_pkg::TEXT_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (accept && in_op == stm_pkg::OP_WRITE_GLYPH) begin
      glyph_mem[in_glyph_index] <= in_glyph_bits;
    end
    glyph_q <= glyph_mem[gaddr];
  end

  a_countdown_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == stm_pkg::OP_TICK && running_r && countdown_r != '0)
      |=> (countdown_r == $past(countdown_r) - 8'd1))
    else $error("frame countdown did not step down");

  a_text_then_glyph: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TEXT) |=> (state_r == ST_GLYPH))
    else $error("character shift not followed by glyph fetch");

  a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_frame.done) |=> !running_r)
    else $error("marquee still running after final frame");

endmodule

`default_nettype wire

FILE: rtl/core/stm_back.sv
// pixel generator: walks a queued frame and emits its 32 pixels through an
// output register; uses stm_pkg
`default_nettype none

module stm_back (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  input  stm_pkg::frame_t  q_frame,
  output logic             q_pop,
  input  wire logic [2:0]  base_row,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_pixel_x,
  output logic [2:0]       out_pixel_y,
  output logic             out_lit,
  output logic             out_last,
  output logic             out_finished
);

  logic             busy_r, busy_nxt;
  stm_pkg::frame_t  cur_r, cur_nxt;
  logic [1:0]       k_r, k_nxt;
  logic [1:0]       row_r, row_nxt;
  logic [1:0]       fx_r, fx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [2:0]       px_r, px_nxt;
  logic [2:0]       py_r, py_nxt;
  logic             lit_r, lit_nxt;
  logic             last_r, last_nxt;
  logic             fin_r, fin_nxt;

  logic             adv;
  logic [1:0]       fx_end;
  logic             last_pix;
  logic [15:0]      cur_glyph;
  logic [3:0]       bit_idx;
  logic [1:0]       k_step;

  assign adv   = !out_valid_r || out_ready;
  assign q_pop = !busy_r && q_valid;

  // letter 0 is clipped on the left, letter 2 on the right
  always_comb begin
    case (k_r)
      2'd0:    fx_end = 2'd3;
      2'd1:    fx_end = 2'd3;
      default: fx_end = cur_r.offset - 2'd1;
    endcase
  end

  always_comb begin
    case (k_r)
      2'd0:    cur_glyph = cur_r.glyphs[0];
      2'd1:    cur_glyph = cur_r.glyphs[1];
      default: cur_glyph = cur_r.glyphs[2];
    endcase
  end

  assign bit_idx  = ~{row_r, fx_r};
  assign last_pix = (row_r == 2'd3) && (fx_r == fx_end) &&
                    (k_r == 2'd2 || (k_r == 2'd1 && cur_r.offset == 2'd0));
  assign k_step   = (row_r == 2'd3) ? k_r + 2'd1 : k_r;

  always_comb begin
    busy_nxt      = busy_r;
    cur_nxt       = cur_r;
    k_nxt         = k_r;
    row_nxt       = row_r;
    fx_nxt        = fx_r;
    out_valid_nxt = out_valid_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    lit_nxt       = lit_r;
    last_nxt      = last_r;
    fin_nxt       = fin_r;
    if (adv) begin
      out_valid_nxt = busy_r;
      if (busy_r) begin
        // 4*k wraps to {k[0],00} modulo the 8-column window
        px_nxt   = {k_r[0], 2'b00} + {1'b0, fx_r} - {1'b0, cur_r.offset};
        py_nxt   = base_row + 3'd3 - {1'b0, row_r};
        lit_nxt  = cur_glyph[bit_idx];
        last_nxt = last_pix;
        fin_nxt  = last_pix && cur_r.done;
        if (last_pix) begin
          busy_nxt = 1'b0;
        end else if (fx_r == fx_end) begin
          k_nxt   = k_step;
          row_nxt = row_r + 2'd1;
          fx_nxt  = (k_step == 2'd0) ? cur_r.offset : 2'd0;
        end else begin
          fx_nxt = fx_r + 2'd1;
        end
      end
    end
    if (q_pop) begin
      busy_nxt = 1'b1;
      cur_nxt  = q_frame;
      k_nxt    = 2'd0;
      row_nxt  = 2'd0;
      fx_nxt   = q_frame.offset;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      row_r       <= '0;
      fx_r        <= '0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
      row_r       <= row_nxt;
      fx_r        <= fx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    lit_r  <= lit_nxt;
    last_r <= last_nxt;
    fin_r  <= fin_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_pixel_x  = px_r;
  assign out_pixel_y  = py_r;
  assign out_lit      = lit_r;
  assign out_last     = last_r;
  assign out_finished = fin_r;

  a_fin_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && fin_r) |-> last_r)
    else $error("finished flag away from the last pixel");

  a_frame_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && adv && last_pix) |=> (!busy_r && out_valid_r && last_r))
    else $error("frame did not close on its last pixel");

  a_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (k_r != 2'd3))
    else $error("pixel walk ran past the third letter");

endmodule

`default_nettype wire

FILE: bench/scrolling_text_marquee_test.sv
// self-checking bench for the scrolling text marquee: drives op transactions and
// register writes, predicts every pixel of every frame and compares in order
// depends on stm_pkg and the scrolling_text_marquee top level
`timescale 1ns / 100ps

module scrolling_text_marquee_test;

  localparam int HALF_PERIOD   = 5;
  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 40;
  localparam int REPORT_LIMIT  = 10;
  localparam int PHASE_ITEMS   = 20;
  localparam int HOLD_CYCLES   = 1000;

  localparam logic [2:0] OP_UNUSED_FIRST   = 3'd5;
  localparam logic [2:0] ADDR_FRAME_PERIOD = 3'd0;
  localparam logic [2:0] ADDR_BASE_ROW     = 3'd4;
  localparam logic [7:0] PERIOD_AT_RESET   = 8'd90;
  localparam logic [7:0] PERIOD_LONGEST    = 8'd255;
  localparam logic [2:0] TOP_BAND_ROW      = 3'd4;

  typedef struct packed {
    logic [2:0] x;
    logic [2:0] y;
    logic       lit;
    logic       last;
    logic       finished;
  } pixel_t;

  // mirrors the marquee state and queues the pixels each tick should produce
  class pixel_tracker;
    logic [7:0]               period_reg;
    logic [2:0]               band_row;
    bit                       running;
    logic [7:0]               countdown;
    logic [1:0]               offset;
    logic [7:0]               window [3];
    logic [stm_pkg::RP_W-1:0] read_pos;
    logic [7:0]               text_mem [stm_pkg::TEXT_DEPTH];
    bit                       text_set [stm_pkg::TEXT_DEPTH];
    logic [15:0]              font [stm_pkg::GLYPH_COUNT];
    pixel_t                   pixels_due [$];
    int                       mismatches;

    function new();
      period_reg = PERIOD_AT_RESET;
      band_row   = 3'd0;
      running    = 1'b0;
      countdown  = 8'd0;
      offset     = 2'd0;
      read_pos   = '0;
      mismatches = 0;
      foreach (window[k]) window[k] = stm_pkg::CHAR_SPACE;
      foreach (text_set[i]) text_set[i] = 1'b0;
    endfunction

    function void write_reg(logic [2:0] addr, logic [31:0] value);
      if (addr == ADDR_FRAME_PERIOD) begin
        period_reg = value[7:0];
      end else if (addr == ADDR_BASE_ROW) begin
        band_row = (value[2:0] > TOP_BAND_ROW) ? TOP_BAND_ROW : value[2:0];
      end
    endfunction

    function logic [5:0] font_slot(logic [7:0] code);
      logic [7:0] idx;
      if (code >= stm_pkg::CHAR_SPACE && code < stm_pkg::CHAR_LOWER) begin
        idx = code - stm_pkg::CHAR_SPACE;
      end else if (code >= stm_pkg::CHAR_LOWER && code < stm_pkg::CHAR_FIRST_OUT) begin
        idx = (code & stm_pkg::FOLD_MASK) - stm_pkg::CHAR_SPACE;
      end else begin
        idx = 8'd0;  // control and high codes draw as a space
      end
      return idx[5:0];
    endfunction

    function void draw(bit done);
      pixel_t      px;
      logic [15:0] g;
      int          x;
      int          row;
      for (int k = 0; k < 3; k++) begin
        g = font[font_slot(window[k])];
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) begin
            x = 4 * k - int'(offset) + c;
            if (x >= 0 && x < 8) begin
              row         = int'(band_row) + 3 - r;
              px.x        = x[2:0];
              px.y        = row[2:0];
              px.lit      = g[15 - (4 * r + c)];
              px.last     = 1'b0;
              px.finished = 1'b0;
              pixels_due.push_back(px);
            end
          end
        end
      end
      px          = pixels_due.pop_back();
      px.last     = 1'b1;
      px.finished = done;
      pixels_due.push_back(px);
    endfunction

    function void take_op(logic [2:0] op, logic [7:0] slot, logic [7:0] code,
                          logic [5:0] gidx, logic [15:0] gbits);
      logic [7:0] next;
      bit         done;
      case (op)
        stm_pkg::OP_WRITE_CHAR: begin
          text_mem[slot] = code;
          text_set[slot] = 1'b1;
        end
        stm_pkg::OP_WRITE_GLYPH: font[gidx] = gbits;
        stm_pkg::OP_START: begin
          foreach (window[k]) window[k] = stm_pkg::CHAR_SPACE;
          read_pos  = '0;
          countdown = 8'd0;
          offset    = 2'd3;
          running   = 1'b1;
        end
        stm_pkg::OP_STOP: running = 1'b0;
        stm_pkg::OP_TICK: begin
          if (running && countdown != 8'd0) begin
            countdown--;
          end else if (running) begin
            countdown = period_reg;
            offset    = offset + 2'd1;
            if (offset == 2'd0) begin
              // past the end of the store reads as the terminator
              next = (read_pos < stm_pkg::TEXT_DEPTH)
                     ? text_mem[read_pos[stm_pkg::TEXT_AW-1:0]] : stm_pkg::CHAR_TERM;
              window[0] = window[1];
              window[1] = window[2];
              window[2] = next;
              if (next != stm_pkg::CHAR_TERM) read_pos++;
            end
            done = (window[0] == stm_pkg::CHAR_TERM);
            if (done) running = 1'b0;
            draw(done);
          end
        end
        default: ;
      endcase
    endfunction

    // true when the next tick would shift in a text slot never loaded
    function bit next_read_blank(output logic [7:0] slot);
      slot = read_pos[7:0];
      return running && countdown == 8'd0 && offset == 2'd3
             && read_pos < stm_pkg::TEXT_DEPTH
             && !text_set[read_pos[stm_pkg::TEXT_AW-1:0]];
    endfunction

    function void match_pixel(logic [2:0] x, logic [2:0] y, logic lit, logic last,
                              logic fin);
      pixel_t want;
      if (pixels_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected pixel x=%0d y=%0d lit=%0b last=%0b finished=%0b",
                   x, y, lit, last, fin);
        return;
      end
      want = pixels_due.pop_front();
      if (want.x !== x || want.y !== y || want.lit !== lit || want.last !== last
          || want.finished !== fin) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display({"pixel mismatch: expected x=%0d y=%0d lit=%0b last=%0b fin=%0b,",
                    " got x=%0d y=%0d lit=%0b last=%0b fin=%0b"},
                   want.x, want.y, want.lit, want.last, want.finished,
                   x, y, lit, last, fin);
      end
    endfunction

    function int pending();
      return pixels_due.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_op;
  logic [7:0]  in_text_slot;
  logic [7:0]  in_char_code;
  logic [5:0]  in_glyph_index;
  logic [15:0] in_glyph_bits;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_pixel_x;
  logic [2:0]  out_pixel_y;
  logic        out_lit;
  logic        out_last;
  logic        out_finished;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pixel_tracker tracker;
  int           send_idle_pct;
  int           recv_idle_pct;
  bit           hold_out = 1'b0;
  int           sent_items = 0;
  int           quiet_cycles = 0;

  scrolling_text_marquee u_top (.*);

  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= hold_out ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.match_pixel(out_pixel_x, out_pixel_y, out_lit, out_last, out_finished);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [7:0] rand_char();
    case ($urandom_range(9))
      0: return 8'($urandom_range(stm_pkg::CHAR_SPACE - 1, 1));
      6, 7: return 8'($urandom_range(stm_pkg::CHAR_FIRST_OUT - 1, stm_pkg::CHAR_LOWER));
      8: return 8'($urandom_range(255, stm_pkg::CHAR_FIRST_OUT));
      default: return 8'($urandom_range(stm_pkg::CHAR_LOWER - 1, stm_pkg::CHAR_SPACE));
    endcase
  endfunction

  // entered and left just after a falling edge
  task automatic send_op(input logic [2:0] op, input logic [7:0] slot,
                         input logic [7:0] code, input logic [5:0] gidx,
                         input logic [15:0] gbits);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_text_slot   <= slot;
    in_char_code   <= code;
    in_glyph_index <= gidx;
    in_glyph_bits  <= gbits;
    do @(posedge clk); while (!in_ready);
    tracker.take_op(op, slot, code, gidx, gbits);
    if (op <= stm_pkg::OP_STOP) sent_items++;
    @(negedge clk);
  endtask

  // op with random payload fields
  task automatic send_bare(input logic [2:0] op);
    send_op(op, 8'($urandom), 8'($urandom), 6'($urandom), 16'($urandom));
  endtask

  task automatic send_tick();
    logic [7:0] slot;
    if (tracker.next_read_blank(slot))
      send_op(stm_pkg::OP_WRITE_CHAR, slot, rand_char(), 6'($urandom), 16'($urandom));
    send_bare(stm_pkg::OP_TICK);
  endtask

  // wait out every pending pixel plus any op still inside the block
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic program_reg(input logic [2:0] addr, input logic [31:0] value);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.write_reg(addr, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // load len chars, start, and tick until it stops or max_ticks ops have gone
  task automatic play_text(input int len, input int max_ticks, input bit noisy);
    int n;
    int r;
    for (int i = 0; i < len; i++)
      send_op(stm_pkg::OP_WRITE_CHAR, i[7:0], rand_char(), 6'($urandom), 16'($urandom));
    if (len < stm_pkg::TEXT_DEPTH)
      send_op(stm_pkg::OP_WRITE_CHAR, len[7:0], stm_pkg::CHAR_TERM, 6'($urandom),
              16'($urandom));
    send_bare(stm_pkg::OP_START);
    n = 0;
    while (tracker.running && n < max_ticks) begin
      r = $urandom_range(99);
      if (!noisy || r >= 20) begin
        send_tick();
      end else if (r < 3) begin
        send_bare(stm_pkg::OP_STOP);
      end else if (r < 6) begin
        send_bare(stm_pkg::OP_START);
      end else if (r < 10) begin
        send_bare(OP_UNUSED_FIRST + 3'($urandom_range(2)));
      end else if (r < 15) begin
        send_bare(stm_pkg::OP_WRITE_GLYPH);
      end else begin
        // may drop a terminator ahead of the read position
        send_bare(stm_pkg::OP_WRITE_CHAR);
      end
      n++;
    end
  endtask

  initial begin
    logic [7:0] sample_text [11];
    int         phase_start;
    sample_text = '{8'h41, 8'h7A, 8'h7F, 8'h60, 8'h1F, 8'h80, 8'hFF, 8'h20, 8'h5F,
                    8'h01, stm_pkg::CHAR_TERM};
    tracker        = new();
    send_idle_pct  = 27;
    recv_idle_pct  = 74;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_op          <= stm_pkg::OP_TICK;
    in_text_slot   <= 8'd0;
    in_char_code   <= 8'd0;
    in_glyph_index <= 6'd0;
    in_glyph_bits  <= 16'd0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= ADDR_FRAME_PERIOD;
    pwdata         <= 32'd0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // whole font first, with a fully lit and a dark glyph
    for (int i = 0; i < stm_pkg::GLYPH_COUNT; i++)
      send_op(stm_pkg::OP_WRITE_GLYPH, 8'($urandom), 8'($urandom), i[5:0],
              (i == 1) ? 16'hFFFF : (i == 2) ? 16'h0000 : 16'($urandom));

    // control, lower case, high and boundary codes
    foreach (sample_text[i])
      send_op(stm_pkg::OP_WRITE_CHAR, i[7:0], sample_text[i], 6'($urandom),
              16'($urandom));
    for (int k = 0; k < 3; k++)
      send_bare(OP_UNUSED_FIRST + 3'(k));
    send_tick();
    send_bare(stm_pkg::OP_STOP);
    send_bare(stm_pkg::OP_START);
    repeat (int'(PERIOD_AT_RESET) + 2) send_tick();
    program_reg(ADDR_BASE_ROW, 32'd7);
    program_reg(ADDR_FRAME_PERIOD, 32'd0);
    repeat (6) send_tick();
    send_bare(stm_pkg::OP_STOP);
    send_tick();
    send_bare(stm_pkg::OP_START);
    while (tracker.running) send_tick();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 27;
          recv_idle_pct = 74;
        end
        1: begin
          send_idle_pct = 74;
          recv_idle_pct = 27;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_start = sent_items;
      while (sent_items - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(3) == 0) begin
          program_reg(ADDR_FRAME_PERIOD, 32'($urandom_range(3)));
          program_reg(ADDR_BASE_ROW, 32'($urandom_range(7)));
        end
        play_text(int'($urandom_range(3)), 30, 1'b1);
      end
    end

    // slowest frame rate, one frame and a few countdown ticks
    program_reg(ADDR_FRAME_PERIOD, 32'(PERIOD_LONGEST));
    play_text(2, 6, 1'b0);

    // short text at full frame rate, with the output held off for a while
    program_reg(ADDR_FRAME_PERIOD, 32'd0);
    program_reg(ADDR_BASE_ROW, 32'(TOP_BAND_ROW));
    fork
      begin
        hold_out = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
      end
    join_none
    play_text(3, 40, 1'b0);

    settle();
    if (tracker.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
